// File: rtl/core/cdc_pkg.sv
// ============================================================================
// cdc_pkg: shared definitions for the common distinct counter
// Command codes, the default table depth, and the command and status
// structures that join the controller and the datapath.
// ============================================================================
package cdc_pkg;

   localparam int CDC_TABLE_DEPTH = 64;
   localparam int CDC_COUNT_W     = 7;
   localparam int CDC_VALUE_W     = 32;

   typedef enum logic [1:0] {
      CMD_CLEAR = 2'd0,
      CMD_ADD   = 2'd1,
      CMD_PROBE = 2'd2
   } cdc_cmd_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;    // capture the incoming transaction
      logic scan;    // step the table scan
      logic commit;  // update the table and load the response register
   } cdc_ctrl_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic needs_scan;  // incoming command is an add or a probe
      logic hit;         // the compare stage found the value this cycle
      logic scan_done;   // every valid entry was compared without a hit
      logic rsp_free;    // the response register can take a new result
   } cdc_stat_type;

endpackage

// File: rtl/core/common_distinct_counter.sv
// ============================================================================
// common_distinct_counter: set intersection cardinality counter
// Counts the distinct values shared by an added sequence and a probed
// sequence, with one response transaction per request transaction.
// ============================================================================
// Each request transaction carries a command and a 32-bit value. A clear
// empties the table and zeroes the common count. An add stores the value
// unless it is already present (matched is set) or the table is full
// (table_full is set and the value is dropped). A probe looks the value up;
// the first probe to hit a stored entry marks it counted and raises the
// common count, later hits only set matched. The unused command code leaves
// the state alone. Every request produces exactly one response with the
// running common count (its low seven bits) and the two flags. The block
// works on one transaction at a time. A clear or the unused code goes
// from acceptance straight to the commit state. An add or a probe
// reads the value RAM one entry per cycle, in order, through a single
// comparator, and stops at the first hit or once every filled entry has
// been compared; on an empty table it reads nothing. A new request may be
// accepted while the previous response still waits on rsp_stall; the
// block only holds off committing the following result until that
// response is taken. The tables need no clearing pass after reset: the
// fill level marks which entries are valid, and each entry's counted
// flag is written whenever the entry is filled.
// ============================================================================
module common_distinct_counter
   import cdc_pkg::*;
#(
   parameter int TABLE_DEPTH = CDC_TABLE_DEPTH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [1:0]                    req_command,
   input  logic signed [CDC_VALUE_W-1:0] req_value,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [CDC_COUNT_W-1:0]        rsp_common_count,
   output logic                          rsp_matched,
   output logic                          rsp_table_full
);

   cdc_ctrl_type ctrl;
   cdc_stat_type stat;

   // The controller sequences accept, scan and commit.
   cdc_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .ctrl      (ctrl)
   );

   // The datapath owns the table RAMs, the scan counter and the response.
   cdc_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .ctrl             (ctrl),
      .stat             (stat),
      .req_command      (req_command),
      .req_value        (req_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_common_count (rsp_common_count),
      .rsp_matched      (rsp_matched),
      .rsp_table_full   (rsp_table_full)
   );

endmodule

// File: rtl/core/cdc_ram.sv
// ============================================================================
// cdc_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; the read data is registered.
// ============================================================================
module cdc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/cdc_controller.sv
// ============================================================================
// cdc_controller: sequencing state machine
// Accepts one transaction, steps the table scan when the command needs it,
// and commits the result once the response register is free.
// ============================================================================
module cdc_controller
   import cdc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  cdc_stat_type stat,
   output cdc_ctrl_type ctrl
);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SCAN   = 3'b010,
      ST_COMMIT = 3'b100
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in    = state_ff;
      ctrl.load   = 1'b0;
      ctrl.scan   = 1'b0;
      ctrl.commit = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               ctrl.load = 1'b1;
               state_in  = stat.needs_scan ? ST_SCAN : ST_COMMIT;
            end
         end
         ST_SCAN: begin
            ctrl.scan = 1'b1;
            if (stat.hit || stat.scan_done) begin
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            if (stat.rsp_free) begin
               ctrl.commit = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);

   // A result is never committed over one that is still waiting.
   a_commit_when_free: assert property (@(posedge clock) disable iff (reset)
      ctrl.commit |-> stat.rsp_free)
      else $error("commit issued while the response register was busy");

   // A loaded transaction always leaves the idle state on the next cycle.
   a_load_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      ctrl.load |=> (state_ff != ST_IDLE))
      else $error("controller stayed idle after accepting a transaction");

endmodule

// File: rtl/core/cdc_datapath.sv
// ============================================================================
// cdc_datapath: table storage, scan compare and result registers
// Holds the stored values and counted flags in RAM, scans entries one per
// cycle, applies the table update and drives the response register.
// ============================================================================
module cdc_datapath
   import cdc_pkg::*;
#(
   parameter int TABLE_DEPTH = CDC_TABLE_DEPTH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  cdc_ctrl_type                  ctrl,
   output cdc_stat_type                  stat,
   input  logic [1:0]                    req_command,
   input  logic signed [CDC_VALUE_W-1:0] req_value,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [CDC_COUNT_W-1:0]        rsp_common_count,
   output logic                          rsp_matched,
   output logic                          rsp_table_full
);

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int FW = $clog2(TABLE_DEPTH + 1);

   logic [1:0]             cmd_ff;
   logic [CDC_VALUE_W-1:0] value_ff;
   logic [FW-1:0]          fill_ff, fill_in;
   logic [FW-1:0]          total_ff, total_in;
   logic [FW-1:0]          idx_ff;
   logic                   pend_ff;
   logic [AW-1:0]          pend_addr_ff;
   logic                   hit_ff;
   logic                   hit_counted_ff;
   logic [AW-1:0]          hit_addr_ff;
   logic                   rsp_valid_ff;
   logic [CDC_COUNT_W-1:0] rsp_count_ff;
   logic                   rsp_matched_ff;
   logic                   rsp_full_ff;

   logic                   issue;
   logic                   hit_now;
   logic                   is_full;
   logic                   matched_in;
   logic                   full_in;
   logic                   val_we;
   logic                   cnt_we;
   logic [AW-1:0]          cnt_addr;
   logic                   cnt_data;
   logic [CDC_VALUE_W-1:0] rd_value;
   logic [0:0]             rd_counted;
   logic [FW+CDC_COUNT_W-1:0] total_ext;

   cdc_ram #(
      .WIDTH (CDC_VALUE_W),
      .DEPTH (TABLE_DEPTH)
   ) u_value_ram (
      .clock   (clock),
      .wr_en   (val_we),
      .wr_addr (fill_ff[AW-1:0]),
      .wr_data (value_ff),
      .rd_en   (issue),
      .rd_addr (idx_ff[AW-1:0]),
      .rd_data (rd_value)
   );

   cdc_ram #(
      .WIDTH (1),
      .DEPTH (TABLE_DEPTH)
   ) u_counted_ram (
      .clock   (clock),
      .wr_en   (cnt_we),
      .wr_addr (cnt_addr),
      .wr_data (cnt_data),
      .rd_en   (issue),
      .rd_addr (idx_ff[AW-1:0]),
      .rd_data (rd_counted)
   );

   assign issue   = ctrl.scan && (idx_ff < fill_ff);
   assign hit_now = pend_ff && (rd_value == value_ff);
   assign is_full = (fill_ff == FW'(TABLE_DEPTH));

   assign stat.needs_scan = (req_command == CMD_ADD) || (req_command == CMD_PROBE);
   assign stat.hit        = hit_now;
   assign stat.scan_done  = !(idx_ff < fill_ff) && !pend_ff;
   assign stat.rsp_free   = !rsp_valid_ff || !rsp_stall;

   // Table update, applied only on commit.
   always_comb begin
      fill_in    = fill_ff;
      total_in   = total_ff;
      matched_in = 1'b0;
      full_in    = 1'b0;
      val_we     = 1'b0;
      cnt_we     = 1'b0;
      cnt_addr   = fill_ff[AW-1:0];
      cnt_data   = 1'b0;
      if (ctrl.commit) begin
         case (cmd_ff)
            CMD_CLEAR: begin
               fill_in  = '0;
               total_in = '0;
            end
            CMD_ADD: begin
               matched_in = hit_ff;
               if (!hit_ff && is_full) begin
                  full_in = 1'b1;
               end else if (!hit_ff) begin
                  val_we  = 1'b1;
                  cnt_we  = 1'b1;
                  fill_in = fill_ff + FW'(1);
               end
            end
            CMD_PROBE: begin
               matched_in = hit_ff;
               if (hit_ff && !hit_counted_ff) begin
                  cnt_we   = 1'b1;
                  cnt_addr = hit_addr_ff;
                  cnt_data = 1'b1;
                  total_in = total_ff + FW'(1);
               end
            end
            default: begin
            end
         endcase
      end
   end

   assign total_ext = {{CDC_COUNT_W{1'b0}}, total_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         total_ff     <= '0;
         idx_ff       <= '0;
         pend_ff      <= 1'b0;
         hit_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fill_ff  <= fill_in;
         total_ff <= total_in;
         if (ctrl.load) begin
            idx_ff  <= '0;
            pend_ff <= 1'b0;
            hit_ff  <= 1'b0;
         end else begin
            pend_ff <= issue;
            if (issue) begin
               idx_ff <= idx_ff + FW'(1);
            end
            if (ctrl.scan && hit_now) begin
               hit_ff <= 1'b1;
            end
         end
         if (ctrl.commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         cmd_ff   <= req_command;
         value_ff <= req_value;
      end
      if (issue) begin
         pend_addr_ff <= idx_ff[AW-1:0];
      end
      if (ctrl.scan && hit_now) begin
         hit_addr_ff    <= pend_addr_ff;
         hit_counted_ff <= rd_counted[0];
      end
      if (ctrl.commit) begin
         rsp_count_ff   <= total_ext[CDC_COUNT_W-1:0];
         rsp_matched_ff <= matched_in;
         rsp_full_ff    <= full_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_common_count = rsp_count_ff;
   assign rsp_matched      = rsp_matched_ff;
   assign rsp_table_full   = rsp_full_ff;

   a_fill_bounded: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FW'(TABLE_DEPTH))
      else $error("fill level ran past the table depth");

   a_total_le_fill: assert property (@(posedge clock) disable iff (reset)
      total_ff <= fill_ff)
      else $error("common total exceeds the number of stored entries");

   a_commit_shows: assert property (@(posedge clock) disable iff (reset)
      ctrl.commit |=> rsp_valid_ff)
      else $error("committed result did not reach the response register");

   a_pend_from_scan: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> $past(ctrl.scan))
      else $error("compare stage active without a scan read");

endmodule

// File: tb/common_distinct_counter_test.sv
`timescale 1ns / 1ps
// ============================================================================
// common_distinct_counter_test: self-checking bench for the distinct counter
// Drives clear, add, probe and unused-code transactions with random bursts
// and gaps against a random response stall pattern. A scoreboard predicts
// every response from its own copy of the table and compares each field.
// ============================================================================
module common_distinct_counter_test;
   import cdc_pkg::*;

   localparam int DEPTH          = CDC_TABLE_DEPTH;
   localparam int RANDOM_ITEMS   = 1050;
   // Cycles without any accepted transaction before the run is declared hung.
   // The slowest correct wait is a full-table scan, a long sender gap and a
   // long stretch of response stalls, all well under this bound.
   localparam int WATCHDOG_LIMIT = 4000;
   // The fourth command code has no meaning; the block must leave its state
   // alone and answer with the current count.
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   typedef struct packed {
      logic [CDC_COUNT_W-1:0] common_count;
      logic                   matched;
      logic                   table_full;
   } answer_type;

   // Scoreboard: keeps its own copy of the value table and the running
   // total, and a queue of the responses that accepted requests will cause.
   class intersection_scoreboard_type;
      logic [CDC_VALUE_W-1:0] entry_value [DEPTH];
      bit                     entry_counted [DEPTH];
      int unsigned            fill_level;
      int unsigned            common_total;
      answer_type             pending_answers [$];
      int unsigned            failures;

      function new();
         failures = 0;
         empty_table();
      endfunction

      function void empty_table();
         fill_level   = 0;
         common_total = 0;
         foreach (entry_counted[i]) entry_counted[i] = 1'b0;
      endfunction

      // Only the filled entries are compared, so unwritten slots never matter.
      function int find_value(logic [CDC_VALUE_W-1:0] value);
         for (int i = 0; i < int'(fill_level); i++) begin
            if (entry_value[i] === value) return i;
         end
         return -1;
      endfunction

      function void note_request(logic [1:0] command, logic [CDC_VALUE_W-1:0] value);
         answer_type answer;
         int         hit;
         answer = '0;
         case (command)
            CMD_CLEAR: begin
               empty_table();
            end
            CMD_ADD: begin
               hit = find_value(value);
               if (hit >= 0) begin
                  answer.matched = 1'b1;
               end else if (fill_level >= DEPTH) begin
                  answer.table_full = 1'b1;
               end else begin
                  entry_value[fill_level]   = value;
                  entry_counted[fill_level] = 1'b0;
                  fill_level++;
               end
            end
            CMD_PROBE: begin
               hit = find_value(value);
               if (hit >= 0) begin
                  answer.matched = 1'b1;
                  if (!entry_counted[hit]) begin
                     entry_counted[hit] = 1'b1;
                     common_total++;
                  end
               end
            end
            default: begin
            end
         endcase
         answer.common_count = common_total[CDC_COUNT_W-1:0];
         pending_answers = {pending_answers, answer};
      endfunction

      function void check_response(logic [CDC_COUNT_W-1:0] count, logic matched,
                                   logic table_full);
         answer_type want;
         if (pending_answers.size() == 0) begin
            $error("response with no request waiting: count %0d, matched %0b, full %0b",
                   count, matched, table_full);
            failures++;
            return;
         end
         want = pending_answers.pop_front();
         if (count !== want.common_count) begin
            $error("common_count mismatch: expected %0d, actual %0d",
                   want.common_count, count);
            failures++;
         end
         if (matched !== want.matched) begin
            $error("matched mismatch: expected %0b, actual %0b", want.matched, matched);
            failures++;
         end
         if (table_full !== want.table_full) begin
            $error("table_full mismatch: expected %0b, actual %0b",
                   want.table_full, table_full);
            failures++;
         end
      endfunction
   endclass

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   logic [1:0]                    req_command = CMD_CLEAR;
   logic signed [CDC_VALUE_W-1:0] req_value = '0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic [CDC_COUNT_W-1:0]        rsp_common_count;
   logic                          rsp_matched;
   logic                          rsp_table_full;

   intersection_scoreboard_type sb;
   int unsigned                 items_sent = 0;
   int unsigned                 burst_left = 0;
   int unsigned                 stuck_cycles = 0;
   int unsigned                 stall_mode = 0;
   int unsigned                 stall_left = 0;

   common_distinct_counter #(
      .TABLE_DEPTH(DEPTH)
   ) u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_command     (req_command),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_common_count(rsp_common_count),
      .rsp_matched     (rsp_matched),
      .rsp_table_full  (rsp_table_full)
   );

   // The clock runs with a 4 ns period.
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Monitor. Both channels are sampled at the rising edge, before any of
   // this edge's updates land, so a transaction is seen exactly when the
   // block takes it. A request is always noted before its response can come.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            sb.note_request(req_command, req_value);
         end
         if (rsp_valid && !rsp_stall) begin
            sb.check_response(rsp_common_count, rsp_matched, rsp_table_full);
         end
      end
   end

   // Response stall pattern. The receiver switches between windows of no
   // stalls, light random stalls and heavy stalls, so that stalls land on
   // every phase of the scan and commit.
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode = $urandom_range(0, 2);
         stall_left = $urandom_range(20, 200);
      end else begin
         stall_left--;
      end
      case (stall_mode)
         0:       rsp_stall <= 1'b0;
         1:       rsp_stall <= ($urandom_range(0, 3) == 0);
         default: rsp_stall <= ($urandom_range(0, 7) != 0);
      endcase
   end

   // Watchdog counter: it restarts on any accepted transaction on either
   // channel and otherwise counts up.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         stuck_cycles <= 0;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   initial begin
      wait (stuck_cycles >= WATCHDOG_LIMIT);
      $display("Some tests failed");
      $finish;
   end

   // Presents one request transaction and holds it until it is accepted.
   // The sender works in bursts; at the end of a burst valid drops for a
   // random gap, mostly short and now and then longer than a full scan.
   task automatic issue_item(input logic [1:0] command, input logic [CDC_VALUE_W-1:0] value);
      int unsigned gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 80) : $urandom_range(1, 4);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
         burst_left = $urandom_range(1, 30);
      end
      burst_left--;
      req_valid   <= 1'b1;
      req_command <= command;
      req_value   <= value;
      do @(posedge clock); while (req_stall);
      items_sent++;
   endtask

   // Holds the sender off until every expected response has arrived. It
   // always waits on the clock before it checks, so valid is never lowered
   // and raised in the same time step.
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending_answers.size() != 0) @(posedge clock);
   endtask

   // Mostly full-range random values, with the sign and range extremes
   // mixed in so that they collide with one another.
   function automatic logic [CDC_VALUE_W-1:0] random_value();
      if ($urandom_range(0, 9) != 0) return $urandom;
      case ($urandom_range(0, 4))
         0:       return 32'h0000_0000;
         1:       return 32'h0000_0001;
         2:       return 32'h7FFF_FFFF;
         3:       return 32'h8000_0000;
         default: return 32'hFFFF_FFFF;
      endcase
   endfunction

   // An occasional stray transaction with any command, the unused code and
   // a stray clear among them, which breaks the sequence in progress.
   task automatic maybe_noise();
      if ($urandom_range(0, 19) == 0) begin
         issue_item(2'($urandom_range(0, 3)), $urandom);
      end
   endtask

   // One well-formed sequence: usually a clear, then adds of a value pool
   // with duplicates, then probes that mostly hit the pool. A filling
   // sequence adds more distinct values than the table holds, so the tail
   // of the adds must come back flagged as dropped. Some sequences mix
   // probes in between the adds.
   task automatic run_sequence(input bit fill_up);
      logic [CDC_VALUE_W-1:0] pool [$];
      logic [CDC_VALUE_W-1:0] v;
      int                     pool_size;
      int                     n_probe;
      int                     i;
      bit                     mixed;
      pool_size = fill_up ? $urandom_range(DEPTH + 2, DEPTH + 8) : $urandom_range(1, 12);
      mixed     = ($urandom_range(0, 2) == 0);
      if ($urandom_range(0, 4) != 0) begin
         issue_item(CMD_CLEAR, $urandom);
      end
      for (i = 0; i < pool_size; i++) begin
         v = fill_up ? $urandom : random_value();
         pool = {pool, v};
         maybe_noise();
         issue_item(CMD_ADD, v);
         if ($urandom_range(0, 3) == 0) begin
            issue_item(CMD_ADD, pool[$urandom_range(0, pool.size() - 1)]);
         end
         if (mixed && $urandom_range(0, 2) == 0) begin
            issue_item(CMD_PROBE, pool[$urandom_range(0, pool.size() - 1)]);
         end
      end
      n_probe = $urandom_range(pool_size / 2 + 1, 2 * pool_size + 2);
      for (i = 0; i < n_probe; i++) begin
         maybe_noise();
         if ($urandom_range(0, 9) < 7) begin
            issue_item(CMD_PROBE, pool[$urandom_range(0, pool.size() - 1)]);
         end else begin
            issue_item(CMD_PROBE, random_value());
         end
      end
   endtask

   initial begin
      sb = new();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part. The table needs no clear after reset, so the first
      // probe must miss on an empty table.
      issue_item(CMD_PROBE, 32'h0000_0000);
      issue_item(CMD_UNUSED, 32'hFFFF_FFFF);
      // Sign and range extremes, then a duplicate add.
      issue_item(CMD_ADD, 32'h0000_0000);
      issue_item(CMD_ADD, 32'h7FFF_FFFF);
      issue_item(CMD_ADD, 32'h8000_0000);
      issue_item(CMD_ADD, 32'hFFFF_FFFF);
      issue_item(CMD_ADD, 32'h0000_0000);
      // First hit counts, a repeated hit only sets matched.
      issue_item(CMD_PROBE, 32'h8000_0000);
      issue_item(CMD_PROBE, 32'h8000_0000);
      issue_item(CMD_PROBE, 32'h7FFF_FFFF);
      issue_item(CMD_PROBE, 32'h1234_5678);
      issue_item(CMD_PROBE, 32'hFFFF_FFFF);
      // The unused code must leave the count where it is.
      issue_item(CMD_UNUSED, 32'h8000_0000);
      issue_item(CMD_ADD, 32'h0000_0001);
      issue_item(CMD_PROBE, 32'h0000_0000);
      // A clear ignores its value and forgets both the entries and the
      // counted marks.
      issue_item(CMD_CLEAR, 32'hA5A5_A5A5);
      issue_item(CMD_PROBE, 32'hFFFF_FFFF);
      issue_item(CMD_ADD, 32'hFFFF_FFFF);
      issue_item(CMD_PROBE, 32'hFFFF_FFFF);
      issue_item(CMD_CLEAR, 32'h0000_0000);
      wait_for_drain();

      // Random part. The first sequence fills the table past its depth.
      items_sent = 0;
      run_sequence(1'b1);
      while (items_sent < RANDOM_ITEMS) begin
         run_sequence($urandom_range(0, 5) == 0);
         if ($urandom_range(0, 7) == 0) begin
            wait_for_drain();
         end
      end

      // Drain, then give any stray response time to show up.
      wait_for_drain();
      repeat (DEPTH + 16) @(posedge clock);
      if (sb.failures == 0 && sb.pending_answers.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
